FILE: hdl/swpm_pkg.sv
// Shared constants and types for the sliding window permutation matcher.
// No dependencies; imported by every module of the block.
package swpm_pkg;

  localparam int LETTER_W = 5;
  localparam int CMD_W    = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PATTERN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEXT    = 2'd2;

  // Update strobes broadcast to every letter cell
  typedef struct packed {
    logic clear;    // clear beat
    logic pat_en;   // accepted pattern letter
    logic take_en;  // text letter enters the window
    logic give_en;  // oldest letter leaves the window
  } swpm_cell_ctl_t;

endpackage

FILE: hdl/swpm_letter_cell.sv
// One letter counter cell: pattern-minus-window balance and pattern membership.
// Depends on swpm_pkg.
module swpm_letter_cell import swpm_pkg::*; #(
  parameter int LETTER_IDX = 0,
  parameter int BAL_W      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  swpm_cell_ctl_t      ctl,
  input  logic [LETTER_W-1:0] new_letter,
  input  logic [LETTER_W-1:0] old_letter,
  output logic                ok
);

  logic [BAL_W-1:0] bal;
  logic [BAL_W-1:0] bal_next;
  logic             in_pat;
  logic             hit_new;
  logic             hit_old;
  logic             up;
  logic             dn;

  assign hit_new = (new_letter == LETTER_W'(LETTER_IDX));
  assign hit_old = (old_letter == LETTER_W'(LETTER_IDX));

  // pattern letters count up; in text, leaving letter gives one back, arriving takes one
  assign up = (ctl.pat_en && hit_new) || (ctl.give_en && hit_old && in_pat);
  assign dn = ctl.take_en && hit_new && in_pat;

  always_comb begin
    unique case ({up, dn})
      2'b10:   bal_next = bal + BAL_W'(1);
      2'b01:   bal_next = bal - BAL_W'(1);
      default: bal_next = bal;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      bal    <= '0;
      in_pat <= 1'b0;
    end else begin
      bal <= bal_next;
      if (ctl.pat_en && hit_new) begin
        in_pat <= 1'b1;
      end
    end
  end

  // letters outside the pattern never block a match
  assign ok = !in_pat || (bal == '0);

endmodule

FILE: hdl/swpm_window_cell.sv
// One slot of the text window shift chain; the oldest letter sits in slot 0.
// Depends on swpm_pkg.
module swpm_window_cell import swpm_pkg::*; (
  input  logic                clk,
  input  logic                shift,
  input  logic                tail,
  input  logic [LETTER_W-1:0] letter_in,
  input  logic [LETTER_W-1:0] from_next,
  output logic [LETTER_W-1:0] letter_q
);

  // tail slot takes the new letter, the others take their neighbor's
  always_ff @(posedge clk) begin
    if (shift) begin
      letter_q <= tail ? letter_in : from_next;
    end
  end

endmodule

FILE: hdl/sliding_window_permutation_match_top.sv
// Sliding window permutation matcher, top level.
// Pipeline: stage 1, output register; letter cells and window chain update on accept.
// Throughput: one beat per cycle unless the output stalls.
// Reset: rst clears counters, flags and pipeline; a clear beat does the same to state.
// The window shift chain has no reset; slots are written before they are read.
module sliding_window_permutation_match_top import swpm_pkg::*; #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic [CMD_W-1:0]    command,
  input  logic [LETTER_W-1:0] letter,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                window_match,
  output logic                found,
  output logic                pattern_overflow
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int BAL_W = LEN_W + 1;

  typedef struct packed {
    logic is_clear;
    logic is_text;
    logic dropped;
    logic full;
  } swpm_stage_t;

  logic                 item_fire;
  logic                 s1_valid;
  logic                 s1_move;
  swpm_stage_t          s1;
  logic [LEN_W-1:0]     pattern_len;
  logic [LEN_W-1:0]     text_seen;
  logic [LEN_W-1:0]     seen_next;
  logic                 text_started;
  logic                 is_clear;
  logic                 is_pat;
  logic                 is_text;
  logic                 pat_ok;
  logic                 text_go;
  logic                 depart;
  logic                 full_after;
  logic                 all_ok;
  logic                 match_new;
  swpm_cell_ctl_t       ctl;
  logic [ALPHABET_SIZE-1:0] cell_ok;
  logic [LETTER_W-1:0]  win_q [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] tail;

  // handshake: stage 1 drains into the output register
  assign s1_move    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_move;
  assign item_fire  = item_valid && item_ready;

  // command decode
  assign is_clear = (command == CMD_CLEAR);
  assign is_pat   = (command == CMD_PATTERN);
  assign is_text  = (command == CMD_TEXT);
  assign pat_ok   = is_pat && !text_started && (int'(letter) < ALPHABET_SIZE)
                    && (int'(pattern_len) < MAX_PATTERN);
  assign text_go  = item_fire && is_text && (pattern_len != '0);
  assign depart   = text_go && (text_seen == pattern_len);

  assign seen_next  = (text_seen < pattern_len) ? text_seen + LEN_W'(1) : text_seen;
  assign full_after = ((text_go ? seen_next : text_seen) == pattern_len);

  // broadcast strobes to letter cells
  assign ctl.clear   = item_fire && is_clear;
  assign ctl.pat_en  = item_fire && pat_ok;
  assign ctl.take_en = text_go;
  assign ctl.give_en = depart;

  // length, text progress and text-started flag; dropped and unused beats hold
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len  <= '0;
      text_seen    <= '0;
      text_started <= 1'b0;
    end else if (item_fire) begin
      if (is_clear) begin
        pattern_len  <= '0;
        text_seen    <= '0;
        text_started <= 1'b0;
      end else if (pat_ok) begin
        pattern_len <= pattern_len + LEN_W'(1);
      end else if (is_text) begin
        text_started <= 1'b1;
        if (pattern_len != '0) begin
          text_seen <= seen_next;
        end
      end
    end
  end

  // letter cells
  for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_letter
    swpm_letter_cell #(
      .LETTER_IDX(g),
      .BAL_W     (BAL_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_letter(letter),
      .old_letter(win_q[0]),
      .ok        (cell_ok[g])
    );
  end

  // window chain: new letters enter at slot pattern_len-1 and move toward slot 0
  for (genvar w = 0; w < MAX_PATTERN; w++) begin : g_window
    logic [LETTER_W-1:0] nbr;
    assign tail[w] = (pattern_len == LEN_W'(w + 1));
    if (w == MAX_PATTERN - 1) begin : g_end
      assign nbr = letter;
    end else begin : g_mid
      assign nbr = win_q[w + 1];
    end
    swpm_window_cell u_slot (
      .clk      (clk),
      .shift    (text_go),
      .tail     (tail[w]),
      .letter_in(letter),
      .from_next(nbr),
      .letter_q (win_q[w])
    );
  end

  // all pattern letters balanced
  assign all_ok    = &cell_ok;
  assign match_new = s1.full && all_ok;

  // stage 1 and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      result_valid     <= 1'b0;
      window_match     <= 1'b0;
      found            <= 1'b0;
      pattern_overflow <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
        priority if (s1.is_clear) begin
          window_match     <= 1'b0;
          found            <= 1'b0;
          pattern_overflow <= 1'b0;
        end else if (s1.is_text) begin
          window_match     <= match_new;
          found            <= found || match_new;
          pattern_overflow <= 1'b0;
        end else begin
          pattern_overflow <= s1.dropped;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1.is_clear <= is_clear;
      s1.is_text  <= is_text;
      s1.dropped  <= is_pat && !pat_ok;
      s1.full     <= full_after;
    end
  end

`ifndef SYNTHESIS
  a_seen_le_len: assert property (@(posedge clk) disable iff (rst)
    text_seen <= pattern_len) else $error("text count passed pattern length");

  a_match_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && window_match |-> found) else $error("match without found");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |-> !item_fire) else $error("stage 1 overwritten");

  a_text_start: assert property (@(posedge clk) disable iff (rst)
    item_fire && (command == CMD_TEXT) |=> text_started)
    else $error("text beat did not mark text started");
`endif

endmodule

FILE: dv/sliding_window_permutation_match_top_tb.sv
// Testbench for sliding_window_permutation_match_top: directed table, then random
// clear/pattern/text sequences checked against an in-bench anagram window predictor.
// Depends on swpm_pkg and the top-level RTL only.
module sliding_window_permutation_match_top_tb import swpm_pkg::*;;

  localparam int ALPHABET     = 26;
  localparam int WINDOW_DEPTH = 64;
  localparam int TARGET_BEATS = 1650;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Expected result beat: {window_match, found, pattern_overflow}
  typedef struct packed {
    logic wm;
    logic fnd;
    logic ovf;
  } verdict_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [LETTER_W-1:0] ch;
    logic                typed;
    verdict_t            exp;
  } plan_row_t;

  // Directed plan; exp is only used where typed is set
  localparam plan_row_t PLAN [24] = '{
    '{CMD_CLEAR,   5'd0,  1'b1, 3'b000},  // clear after reset
    '{CMD_TEXT,    5'd0,  1'b1, 3'b110},  // empty pattern matches at once
    '{CMD_TEXT,    5'd31, 1'b1, 3'b110},  // and keeps matching, any letter
    '{CMD_UNUSED,  5'd0,  1'b1, 3'b110},  // unused command holds flags
    '{CMD_PATTERN, 5'd0,  1'b1, 3'b111},  // pattern letter after text is dropped
    '{CMD_CLEAR,   5'd0,  1'b1, 3'b000},
    '{CMD_PATTERN, 5'd31, 1'b1, 3'b001},  // out-of-range pattern letters
    '{CMD_PATTERN, 5'd26, 1'b1, 3'b001},
    '{CMD_PATTERN, 5'd0,  1'b1, 3'b000},
    '{CMD_PATTERN, 5'd25, 1'b1, 3'b000},
    '{CMD_PATTERN, 5'd25, 1'b1, 3'b000},
    '{CMD_TEXT,    5'd25, 1'b0, 3'b000},
    '{CMD_TEXT,    5'd0,  1'b0, 3'b000},
    '{CMD_TEXT,    5'd25, 1'b0, 3'b000},
    '{CMD_TEXT,    5'd31, 1'b0, 3'b000},  // out-of-range text letter fills a slot
    '{CMD_TEXT,    5'd25, 1'b0, 3'b000},
    '{CMD_TEXT,    5'd0,  1'b0, 3'b000},
    '{CMD_TEXT,    5'd25, 1'b0, 3'b000},
    '{CMD_UNUSED,  5'd31, 1'b0, 3'b000},
    '{CMD_TEXT,    5'd10, 1'b0, 3'b000},  // letter not in pattern
    '{CMD_CLEAR,   5'd0,  1'b1, 3'b000},
    '{CMD_PATTERN, 5'd21, 1'b1, 3'b000},
    '{CMD_TEXT,    5'd10, 1'b0, 3'b000},
    '{CMD_TEXT,    5'd21, 1'b0, 3'b000}
  };

  logic                clk = 1'b0;
  logic                rst;
  logic                item_valid;
  logic                item_ready;
  logic [CMD_W-1:0]    command;
  logic [LETTER_W-1:0] letter;
  logic                result_valid;
  logic                result_ready;
  logic                window_match;
  logic                found;
  logic                pattern_overflow;

  sliding_window_permutation_match_top dut (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_ready       (item_ready),
    .command          (command),
    .letter           (letter),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .window_match     (window_match),
    .found            (found),
    .pattern_overflow (pattern_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: per-letter tally is pattern count minus window count
  int                  tally [ALPHABET];
  bit                  wanted [ALPHABET];
  logic [LETTER_W-1:0] ring [WINDOW_DEPTH];
  int                  ring_head;
  int                  pat_len;
  int                  kinds_needed;
  int                  kinds_balanced;
  int                  window_fill;
  bit                  found_on;
  bit                  text_on;
  bit                  match_live;

  verdict_t expected_q [$];
  int       errors;
  int       beats_sent;
  bit       quiet;

  task automatic clear_matcher();
    for (int i = 0; i < ALPHABET; i++) begin
      tally[i]  = 0;
      wanted[i] = 1'b0;
    end
    ring_head      = 0;
    pat_len        = 0;
    kinds_needed   = 0;
    kinds_balanced = 0;
    window_fill    = 0;
    found_on       = 1'b0;
    text_on        = 1'b0;
    match_live     = 1'b0;
  endtask

  // Move one letter's tally; track how many pattern letters sit at zero
  task automatic shift_tally(input logic [LETTER_W-1:0] ch, input int delta);
    if (ch >= ALPHABET || !wanted[ch]) return;
    if (tally[ch] == 0) kinds_balanced--;
    tally[ch] += delta;
    if (tally[ch] == 0) kinds_balanced++;
  endtask

  task automatic predict_match(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] ch,
                               output verdict_t v);
    logic dropped;
    int   oldest;
    dropped = 1'b0;
    case (cmd)
      CMD_CLEAR: clear_matcher();
      CMD_PATTERN: begin
        if (text_on || ch >= ALPHABET || pat_len >= WINDOW_DEPTH) begin
          dropped = 1'b1;
        end else begin
          if (!wanted[ch]) begin
            wanted[ch] = 1'b1;
            kinds_needed++;
          end
          tally[ch]++;
          pat_len++;
        end
      end
      CMD_TEXT: begin
        text_on = 1'b1;
        if (pat_len != 0) begin
          // oldest letter leaves once the window is full
          if (window_fill == pat_len) begin
            oldest = (ring_head + WINDOW_DEPTH - pat_len) % WINDOW_DEPTH;
            shift_tally(ring[oldest], 1);
          end
          shift_tally(ch, -1);
          ring[ring_head] = ch;
          ring_head = (ring_head + 1) % WINDOW_DEPTH;
          if (window_fill < pat_len) window_fill++;
        end
        match_live = (window_fill == pat_len) && (kinds_balanced == kinds_needed);
        if (match_live) found_on = 1'b1;
      end
      CMD_UNUSED: ;
    endcase
    v.wm  = match_live;
    v.fnd = found_on;
    v.ovf = dropped;
  endtask

  // Mostly no gap, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  // Drive one input beat, wait for acceptance, predict, then maybe idle
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] ch,
                           input logic typed = 1'b0, input verdict_t typed_v = '0);
    verdict_t v;
    int       gap;
    item_valid <= 1'b1;
    command    <= cmd;
    letter     <= ch;
    do @(posedge clk); while (!item_ready);
    predict_match(cmd, ch, v);
    if (typed) v = typed_v;
    expected_q.push_back(v);
    if (cmd != CMD_UNUSED) beats_sent++;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result sink: ready in runs, sometimes long, with random stalls between
  initial begin
    int run;
    int gap;
    result_ready <= 1'b0;
    repeat (3) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 20);
      repeat (run) begin
        @(posedge clk);
        result_ready <= 1'b1;
      end
      gap = idle_len();
      repeat (gap) begin
        @(posedge clk);
        result_ready <= 1'b0;
      end
    end
  end

  // Compare each result beat against the oldest expectation
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        $error("result beat with no expectation pending");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (window_match !== e.wm) begin
          $error("window_match: expected %0b, got %0b", e.wm, window_match);
          errors++;
        end
        if (found !== e.fnd) begin
          $error("found: expected %0b, got %0b", e.fnd, found);
          errors++;
        end
        if (pattern_overflow !== e.ovf) begin
          $error("pattern_overflow: expected %0b, got %0b", e.ovf, pattern_overflow);
          errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int                  subset [5];
    int                  pat_q [$];
    int                  feed_q [$];
    int                  nsub;
    int                  plen;
    int                  tlen;
    int                  sel;
    int                  feed_pct;
    int                  j;
    int                  tmp;
    int                  guard;
    bit                  first_full;
    logic [LETTER_W-1:0] c;

    errors     = 0;
    beats_sent = 0;
    quiet      = 1'b0;
    first_full = 1'b1;
    clear_matcher();
    rst        <= 1'b1;
    item_valid <= 1'b0;
    command    <= CMD_CLEAR;
    letter     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (PLAN[i]) send_beat(PLAN[i].cmd, PLAN[i].ch, PLAN[i].typed, PLAN[i].exp);

    // Random sequences
    while (beats_sent < TARGET_BEATS) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 99) < 85) begin
        // Well-formed: clear, pattern, then a text stream over a small alphabet
        sel = $urandom_range(0, 99);
        if (first_full) begin
          plen = 66;  // fills the store and runs past it
          first_full = 1'b0;
        end else if (sel < 80) begin
          plen = $urandom_range(1, 8);
        end else if (sel < 94) begin
          plen = $urandom_range(9, 40);
        end else begin
          plen = $urandom_range(58, 70);
        end
        nsub = $urandom_range(1, 5);
        for (int i = 0; i < nsub; i++) subset[i] = $urandom_range(0, ALPHABET - 1);
        send_beat(CMD_CLEAR, LETTER_W'($urandom_range(0, 31)));
        pat_q.delete();
        for (int i = 0; i < plen; i++) begin
          if ($urandom_range(0, 29) == 0) begin
            send_beat(CMD_PATTERN, LETTER_W'($urandom_range(ALPHABET, 31)));
          end else begin
            c = LETTER_W'(subset[$urandom_range(0, nsub - 1)]);
            send_beat(CMD_PATTERN, c);
            if (pat_q.size() < WINDOW_DEPTH) pat_q.push_back(c);
          end
        end
        tlen     = pat_q.size() + $urandom_range(0, 2 * pat_q.size() + 12);
        feed_pct = $urandom_range(0, 1) ? 100 : $urandom_range(40, 90);
        feed_q.delete();
        for (int i = 0; i < tlen; i++) begin
          // refill with a shuffled copy of the pattern to provoke matches
          if (feed_q.size() == 0 && $urandom_range(0, 99) < 30) begin
            feed_q = pat_q;
            for (int k = feed_q.size() - 1; k > 0; k--) begin
              j = $urandom_range(0, k);
              tmp = feed_q[k];
              feed_q[k] = feed_q[j];
              feed_q[j] = tmp;
            end
          end
          sel = $urandom_range(0, 99);
          if (feed_q.size() != 0 && sel < feed_pct) begin
            send_beat(CMD_TEXT, LETTER_W'(feed_q.pop_front()));
          end else begin
            sel = $urandom_range(0, 99);
            if (sel < 88) send_beat(CMD_TEXT, LETTER_W'(subset[$urandom_range(0, nsub - 1)]));
            else if (sel < 94) send_beat(CMD_TEXT, LETTER_W'($urandom_range(0, 31)));
            else if (sel < 97) send_beat(CMD_PATTERN, LETTER_W'($urandom_range(0, 31)));
            else send_beat(CMD_UNUSED, LETTER_W'($urandom_range(0, 31)));
          end
        end
      end else begin
        // Noise: any command, any letter code
        plen = $urandom_range(5, 20);
        for (int i = 0; i < plen; i++)
          send_beat(CMD_W'($urandom_range(0, 3)), LETTER_W'($urandom_range(0, 31)));
      end
    end
    item_valid <= 1'b0;

    // Drain, then allow for the stage 1 and output registers
    guard = 0;
    while (expected_q.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
